>>> rtl/otam_pkg.sv
// Shared types and constants for the ordinal time axis map.
// No dependencies; used by otam_frac_div and ordinal_time_axis_map_top.
package otam_pkg;

    localparam int STAMP_W     = 64;
    localparam int POS_W       = 28;
    localparam int COORD_W     = 26;
    localparam int OSTAMP_W    = 63;
    localparam int COUNT_W     = 11;
    localparam int IN_TDATA_W  = 96;   // stamp + position, padded to bytes
    localparam int OUT_TDATA_W = 104;  // coord + stamp + status + count, padded

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_REV   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NONPOS   = 2'd1,
        STS_ORDER    = 2'd2,
        STS_OVERFLOW = 2'd3
    } status_t;

endpackage

>>> rtl/otam_frac_div.sv
// Restoring divider producing the interpolation fraction, one bit per cycle.
// Depends on otam_pkg (stamp width).
module otam_frac_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [otam_pkg::STAMP_W-1:0]  num,
    input  logic [otam_pkg::STAMP_W-1:0]  den,
    output logic                          done,
    output logic [FRAC_BITS-1:0]          frac
);

    localparam int NW = $clog2(FRAC_BITS + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [NW-1:0]                 cnt_reg;
    logic [otam_pkg::STAMP_W-1:0]  rem_reg;
    logic [otam_pkg::STAMP_W-1:0]  den_reg;
    logic [FRAC_BITS-1:0]          frac_reg;
    logic [otam_pkg::STAMP_W:0]    shifted;
    logic                          take;

    assign shifted = {rem_reg, 1'b0};
    assign take    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == NW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? otam_pkg::STAMP_W'(shifted - {1'b0, den_reg})
                             : shifted[otam_pkg::STAMP_W-1:0];
            frac_reg <= {frac_reg[FRAC_BITS-2:0], take};
        end
    end

    assign done = done_reg;
    assign frac = frac_reg;

endmodule

>>> rtl/ordinal_time_axis_map_top.sv
// Ordinal time axis map: double-banked sorted timestamp table with
// binary-search interpolation. Depends on otam_pkg and otam_frac_div.
//
//  channel | direction | tdata (low bit up)             | tuser   | tlast
//  --------+-----------+--------------------------------+---------+------------
//  s_*     | in        | stamp[63:0], position[91:64]   | command | final_entry
//  m_*     | out       | coord_out, stamp_out, status,  | -       | -
//          |           | entry_count                    |         |
//
// A load or clear beat passes through the execute and finish states; a
// reverse query adds one table read. A forward query makes its table reads
// in turn (first, last, about log2(count) search probes, upper, lower), then
// runs the divider; it ends early when the stamp lies outside or on an entry.
// The single table read port and the one divider set this order.
// Reset is asynchronous, active low; the table RAM itself is not cleared.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register and a new beat is taken meanwhile, but the next
// result stalls until m_tready drains the previous one.
module ordinal_time_axis_map_top #(
    parameter int DEPTH     = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [otam_pkg::IN_TDATA_W-1:0]   s_tdata,  // stamp, position, pad
    input  logic [1:0]                        s_tuser,  // command
    input  logic                              s_tlast,  // final_entry
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [otam_pkg::OUT_TDATA_W-1:0]  m_tdata   // coord_out, stamp_out,
                                                        // status, entry_count, pad
);

    localparam int CW = $clog2(DEPTH + 1);  // counts 0..DEPTH
    localparam int IW = $clog2(DEPTH);      // entry index
    localparam int AW = $clog2(2 * DEPTH);  // both banks
    localparam int XW = CW + FRAC_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_WAIT   = 6'b000100,
        ST_USE    = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_LAST   = 3'd1,
        PH_SEARCH = 3'd2,
        PH_UPPER  = 3'd3,
        PH_LOWER  = 3'd4,
        PH_REV    = 3'd5
    } phase_t;

    // control state
    state_t                          state_reg, state_next;
    logic                            active_bank_reg, active_bank_next;
    logic [CW-1:0]                   active_count_reg, active_count_next;
    logic [CW-1:0]                   load_count_reg, load_count_next;
    logic [1:0]                      load_err_reg, load_err_next;
    logic [otam_pkg::STAMP_W-1:0]    prev_stamp_reg, prev_stamp_next;
    logic                            out_valid_reg, out_valid_next;

    // payload
    phase_t                          phase_reg, phase_next;
    otam_pkg::cmd_t                  cmd_reg;
    logic [otam_pkg::STAMP_W-1:0]    stamp_reg;
    logic [otam_pkg::POS_W-1:0]      pos_reg;
    logic                            last_reg;
    logic [CW-1:0]                   lo_reg, lo_next;
    logic [CW-1:0]                   hi_reg, hi_next;
    logic [CW-1:0]                   up_reg, up_next;
    logic [otam_pkg::STAMP_W-1:0]    upper_reg, upper_next;
    logic [AW-1:0]                   rd_addr_reg, rd_addr_next;
    logic [otam_pkg::STAMP_W-1:0]    rdata_reg;
    logic [otam_pkg::COORD_W-1:0]    res_coord_reg, res_coord_next;
    logic [otam_pkg::OSTAMP_W-1:0]   res_stamp_reg, res_stamp_next;
    logic [1:0]                      res_status_reg, res_status_next;
    logic [otam_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [otam_pkg::STAMP_W-1:0]    mem [2*DEPTH];
    logic                            we;
    logic [AW-1:0]                   wr_addr;

    logic                            in_fire;
    logic [CW-1:0]                   n_minus1;
    logic [CW-1:0]                   cur_mid;
    logic [32:0]                     rev_sum;
    logic [32:0]                     rev_idx;
    logic [CW-1:0]                   rev_pick;
    logic [1:0]                      err_now;
    logic [CW-1:0]                   cnt_now;
    logic [CW-1:0]                   search_lo, search_hi;

    logic                            div_start;
    logic                            div_done;
    logic [FRAC_BITS-1:0]            div_frac;

    function automatic logic [AW-1:0] tab_addr(input logic bank, input logic [IW-1:0] idx);
        tab_addr = bank ? AW'(DEPTH) + AW'(idx) : AW'(idx);
    endfunction

    function automatic logic [otam_pkg::COORD_W-1:0] coord_of(input logic [CW-1:0] idx,
                                                              input logic [FRAC_BITS-1:0] f);
        logic [XW-1:0] w;
        w = {idx, f};
        coord_of = otam_pkg::COORD_W'(w);
    endfunction

    // midpoint of a search window, floor((a + b) / 2)
    function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        mid_of = s[CW:1];
    endfunction

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign n_minus1 = active_count_reg - 1'b1;
    assign cur_mid  = mid_of(lo_reg, hi_reg);

    // reverse query index: round half up, clamp to the last entry
    assign rev_sum  = 33'(pos_reg) + (33'(1) << (FRAC_BITS - 1));
    assign rev_idx  = rev_sum >> FRAC_BITS;
    assign rev_pick = (rev_idx > 33'(n_minus1)) ? n_minus1 : CW'(rev_idx);

    otam_frac_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (stamp_reg - rdata_reg),
        .den   (upper_reg - rdata_reg),
        .done  (div_done),
        .frac  (div_frac)
    );

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        active_bank_next  = active_bank_reg;
        active_count_next = active_count_reg;
        load_count_next   = load_count_reg;
        load_err_next     = load_err_reg;
        prev_stamp_next   = prev_stamp_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        up_next           = up_reg;
        upper_next        = upper_reg;
        rd_addr_next      = rd_addr_reg;
        res_coord_next    = res_coord_reg;
        res_stamp_next    = res_stamp_reg;
        res_status_next   = res_status_reg;
        we                = 1'b0;
        wr_addr           = tab_addr(~active_bank_reg, load_count_reg[IW-1:0]);
        err_now           = load_err_reg;
        cnt_now           = load_count_reg;
        search_lo         = lo_reg;
        search_hi         = hi_reg;
        div_start         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                res_coord_next  = '0;
                res_stamp_next  = '0;
                res_status_next = otam_pkg::STS_OK;
                state_next      = ST_FINISH;
                case (cmd_reg)
                    otam_pkg::CMD_LOAD:
                    begin
                        // first error sticks for the rest of the load
                        if (load_err_reg == otam_pkg::STS_OK)
                        begin
                            if (stamp_reg == '0 || stamp_reg[otam_pkg::STAMP_W-1])
                                err_now = otam_pkg::STS_NONPOS;
                            else if (load_count_reg != '0 && stamp_reg <= prev_stamp_reg)
                                err_now = otam_pkg::STS_ORDER;
                            else if (load_count_reg >= CW'(DEPTH))
                                err_now = otam_pkg::STS_OVERFLOW;
                            else
                            begin
                                we              = 1'b1;
                                cnt_now         = load_count_reg + 1'b1;
                                prev_stamp_next = stamp_reg;
                            end
                        end
                        load_err_next   = err_now;
                        load_count_next = cnt_now;
                        res_status_next = err_now;
                        if (last_reg)
                        begin
                            if (err_now == otam_pkg::STS_OK && cnt_now != '0)
                            begin
                                active_bank_next  = ~active_bank_reg;
                                active_count_next = cnt_now;
                            end
                            load_count_next = '0;
                            load_err_next   = otam_pkg::STS_OK;
                            prev_stamp_next = '0;
                        end
                    end
                    otam_pkg::CMD_FWD:
                    begin
                        if (active_count_reg == CW'(1))
                            res_coord_next = otam_pkg::COORD_W'(
                                XW'(1) << (FRAC_BITS - 1));
                        else if (active_count_reg != '0)
                        begin
                            rd_addr_next = tab_addr(active_bank_reg, '0);
                            phase_next   = PH_FIRST;
                            state_next   = ST_WAIT;
                        end
                    end
                    otam_pkg::CMD_REV:
                    begin
                        if (active_count_reg != '0)
                        begin
                            if (active_count_reg == CW'(1) || pos_reg[otam_pkg::POS_W-1])
                                rd_addr_next = tab_addr(active_bank_reg, '0);
                            else
                                rd_addr_next = tab_addr(active_bank_reg, rev_pick[IW-1:0]);
                            phase_next = PH_REV;
                            state_next = ST_WAIT;
                        end
                    end
                    otam_pkg::CMD_CLEAR:
                    begin
                        active_count_next = '0;
                        load_count_next   = '0;
                        load_err_next     = otam_pkg::STS_OK;
                        prev_stamp_next   = '0;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_WAIT:
            begin
                state_next = ST_USE;
            end

            ST_USE:
            begin
                state_next = ST_WAIT;
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if ($signed(stamp_reg) <= $signed(rdata_reg))
                            state_next = ST_FINISH;
                        else
                        begin
                            rd_addr_next = tab_addr(active_bank_reg, n_minus1[IW-1:0]);
                            phase_next   = PH_LAST;
                        end
                    end
                    PH_LAST:
                    begin
                        if ($signed(stamp_reg) >= $signed(rdata_reg))
                        begin
                            res_coord_next = coord_of(n_minus1, '0);
                            state_next     = ST_FINISH;
                        end
                        else
                        begin
                            search_lo    = '0;
                            search_hi    = active_count_reg;
                            lo_next      = search_lo;
                            hi_next      = search_hi;
                            rd_addr_next = tab_addr(active_bank_reg,
                                                    IW'(mid_of(search_lo, search_hi)));
                            phase_next   = PH_SEARCH;
                        end
                    end
                    PH_SEARCH:
                    begin
                        // lower-bound search: first entry not below the query
                        if ($signed(rdata_reg) < $signed(stamp_reg))
                            search_lo = cur_mid + 1'b1;
                        else
                            search_hi = cur_mid;
                        lo_next = search_lo;
                        hi_next = search_hi;
                        if (search_lo < search_hi)
                            rd_addr_next = tab_addr(active_bank_reg,
                                                    IW'(mid_of(search_lo, search_hi)));
                        else
                        begin
                            up_next      = search_lo;
                            rd_addr_next = tab_addr(active_bank_reg, search_lo[IW-1:0]);
                            phase_next   = PH_UPPER;
                        end
                    end
                    PH_UPPER:
                    begin
                        upper_next = rdata_reg;
                        if (rdata_reg == stamp_reg)
                        begin
                            res_coord_next = coord_of(up_reg, '0);
                            state_next     = ST_FINISH;
                        end
                        else
                        begin
                            lo_next      = up_reg - 1'b1;
                            rd_addr_next = tab_addr(active_bank_reg,
                                                    IW'(up_reg - 1'b1));
                            phase_next   = PH_LOWER;
                        end
                    end
                    PH_LOWER:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    PH_REV:
                    begin
                        res_stamp_next = rdata_reg[otam_pkg::OSTAMP_W-1:0];
                        state_next     = ST_FINISH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    res_coord_next = coord_of(lo_reg, div_frac);
                    state_next     = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = otam_pkg::OUT_TDATA_W'({
                        otam_pkg::COUNT_W'(active_count_reg),
                        res_status_reg,
                        res_stamp_reg,
                        res_coord_reg});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_bank_reg  <= 1'b0;
            active_count_reg <= '0;
            load_count_reg   <= '0;
            load_err_reg     <= otam_pkg::STS_OK;
            prev_stamp_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_bank_reg  <= active_bank_next;
            active_count_reg <= active_count_next;
            load_count_reg   <= load_count_next;
            load_err_reg     <= load_err_next;
            prev_stamp_reg   <= prev_stamp_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= otam_pkg::cmd_t'(s_tuser);
            stamp_reg <= s_tdata[otam_pkg::STAMP_W-1:0];
            pos_reg   <= s_tdata[otam_pkg::STAMP_W +: otam_pkg::POS_W];
            last_reg  <= s_tlast;
        end
        phase_reg      <= phase_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        up_reg         <= up_next;
        upper_reg      <= upper_next;
        rd_addr_reg    <= rd_addr_next;
        res_coord_reg  <= res_coord_next;
        res_stamp_reg  <= res_stamp_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    // table RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= stamp_reg;
        rdata_reg <= mem[rd_addr_reg];
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (active_count_reg <= CW'(DEPTH)) && (load_count_reg <= CW'(DEPTH)))
        else $error("table count beyond depth");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside division state");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    a_load_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (load_err_reg == otam_pkg::STS_OK) && (state_reg == ST_EXEC))
        else $error("table write during failed load");

endmodule
